@@ rtl/core/fra_pkg.sv @@
// shared types and constants of the range-add / range-sum store
`default_nettype none

package fra_pkg;

  // fixed field widths
  localparam int unsigned WORD_W = 64;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned VAL_W  = 32;

  // item kinds
  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_SUM = 1'b1
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SUM_RD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ADD,
    ST_ACC
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/fra_ram.sv @@
// single-write, single-read synchronous tree memory, registered read data
`default_nettype none

module fra_ram #(
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned AW    = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [fra_pkg::WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [fra_pkg::WORD_W-1:0] rdata_o
);
  import fra_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/fenwick_range_add_range_sum.sv @@
// top level: range-add / range-sum store built on two fenwick trees
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  command  | start, busy (out), mode_i, lo_index_i,            | in
//           | hi_index_i, add_value_i                          |
//  result   | valid_o, range_total_o                           | out
//
// After reset a clearing pass writes zero to every tree entry with busy high.
// A range add runs ST_PREP_A and ST_PREP_B, then two upward walks, from lo
// and from hi+1, each of at most log2(SIZE)+1 steps; every walk step is a
// read then a write of the same entry in both tree memories. A range sum
// walks down from hi and from lo-1, issuing reads one per cycle, and scales
// each prefix in ST_MUL_LO, ST_MUL_HI, ST_MUL_ADD and ST_ACC. The result
// shows on valid_o for one cycle as busy falls; the receiver cannot stall.
`default_nettype none

module fenwick_range_add_range_sum #(
  parameter int unsigned SIZE = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode_i,
  input  wire logic [10:0]        lo_index_i,
  input  wire logic [10:0]        hi_index_i,
  input  wire logic signed [31:0] add_value_i,
  output logic                    valid_o,
  output logic signed [63:0]      range_total_o
);
  import fra_pkg::*;

  localparam int unsigned AW    = $clog2(SIZE + 1);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned CW    = (PW > IDX_W) ? PW : IDX_W;
  localparam int unsigned DEPTH = SIZE + 1;

  state_e state_q, state_d;

  // item registers
  logic [PW-1:0]           lo_q, lo_d;
  logic [AW-1:0]           hi_q, hi_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  // walk and arithmetic registers
  logic [PW-1:0]     pos_q, pos_d;
  logic              phase_q, phase_d;
  logic              rv_q, rv_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [WORD_W-1:0] off_a_q, off_a_d, off_b_q, off_b_d;
  logic [WORD_W-1:0] s_acc_q, s_acc_d, o_acc_q, o_acc_d;
  logic [WORD_W-1:0] mlo_q, mlo_d, term_q, term_d, total_q, total_d;
  logic [31:0]       mhi_q, mhi_d;
  logic              valid_q, valid_d;
  logic [WORD_W-1:0] result_q, result_d;

  // memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] slope_wdata, offset_wdata, slope_rdata, offset_rdata;

  // combinational helpers
  logic              accept;
  logic [CW-1:0]     lo_ext, hi_ext, lo_clamp, hi_clamp;
  logic [AW-1:0]     lo_m1, x_w;
  logic              walk_end;
  logic [PW-1:0]     low_bit;
  logic [WORD_W-1:0] vext, d_slope, d_off;
  logic signed [AW:0]      xs;
  logic signed [AW+32:0]   sprod;
  logic [WORD_W-1:0]       sprod_ext;
  logic [32+AW-1:0]        mprod;
  logic [31:0]             mprod_hi;

  assign accept = start && !busy;

  // clamp the incoming range to the stored positions
  always_comb begin
    lo_ext = CW'(lo_index_i);
    hi_ext = CW'(hi_index_i);
    if (lo_ext == '0) begin
      lo_clamp = CW'(1);
    end else if (lo_ext > CW'(SIZE + 1)) begin
      lo_clamp = CW'(SIZE + 1);
    end else begin
      lo_clamp = lo_ext;
    end
    if (hi_ext > CW'(SIZE)) begin
      hi_clamp = CW'(SIZE);
    end else begin
      hi_clamp = hi_ext;
    end
  end

  // walk helpers
  assign lo_m1    = AW'(lo_q - PW'(1));
  assign x_w      = phase_q ? lo_m1 : hi_q;
  assign walk_end = (pos_q > PW'(SIZE));
  assign low_bit  = pos_q & (~pos_q + PW'(1));
  assign vext     = {{(WORD_W-VAL_W){val_q[VAL_W-1]}}, val_q};
  assign d_slope  = phase_q ? (WORD_W'(0) - vext) : vext;
  assign d_off    = phase_q ? off_b_q : off_a_q;

  // signed offset product: position times add value
  assign xs        = {1'b0, (state_q == ST_PREP_A) ? lo_m1 : hi_q};
  assign sprod     = xs * val_q;
  assign sprod_ext = {{(WORD_W-AW-33){sprod[AW+32]}}, sprod};

  // prefix scaling, split into low and high halves
  assign mprod    = (32+AW)'(s_acc_q[31:0]) * (32+AW)'(x_w);
  assign mprod_hi = s_acc_q[63:32] * 32'(x_w);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (clr_q == AW'(SIZE)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = (mode_i == MODE_ADD) ? ST_PREP_A : ST_SUM_RD;
        end
      end
      ST_PREP_A:  state_d = ST_PREP_B;
      ST_PREP_B:  state_d = ST_UPD_RD;
      ST_UPD_RD: begin
        if (!walk_end) begin
          state_d = ST_UPD_WR;
        end else if (phase_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_UPD_WR:  state_d = ST_UPD_RD;
      ST_SUM_RD:  if (pos_q == '0) state_d = ST_MUL_LO;
      ST_MUL_LO:  state_d = ST_MUL_HI;
      ST_MUL_HI:  state_d = ST_MUL_ADD;
      ST_MUL_ADD: state_d = ST_ACC;
      ST_ACC:     state_d = phase_q ? ST_IDLE : ST_SUM_RD;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy         = (state_q != ST_IDLE);
    mem_we       = 1'b0;
    mem_waddr    = pos_q[AW-1:0];
    mem_raddr    = '0;
    slope_wdata  = slope_rdata + d_slope;
    offset_wdata = offset_rdata + d_off;
    case (state_q)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_q;
        slope_wdata  = '0;
        offset_wdata = '0;
      end
      ST_UPD_RD: if (!walk_end) mem_raddr = pos_q[AW-1:0];
      ST_UPD_WR: mem_we = 1'b1;
      ST_SUM_RD: mem_raddr = pos_q[AW-1:0];
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    val_d    = val_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    rv_d     = 1'b0;
    clr_d    = clr_q;
    off_a_d  = off_a_q;
    off_b_d  = off_b_q;
    s_acc_d  = s_acc_q;
    o_acc_d  = o_acc_q;
    mlo_d    = mlo_q;
    mhi_d    = mhi_q;
    term_d   = term_q;
    total_d  = total_q;
    valid_d  = 1'b0;
    result_d = result_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + AW'(1);
      ST_IDLE: begin
        if (accept) begin
          lo_d    = PW'(lo_clamp);
          hi_d    = AW'(hi_clamp);
          val_d   = add_value_i;
          phase_d = 1'b0;
          pos_d   = (mode_i == MODE_ADD) ? PW'(lo_clamp) : PW'(hi_clamp);
          s_acc_d = '0;
          o_acc_d = '0;
          total_d = '0;
        end
      end
      ST_PREP_A: off_a_d = WORD_W'(0) - sprod_ext;
      ST_PREP_B: off_b_d = sprod_ext;
      ST_UPD_RD: begin
        if (walk_end && !phase_q) begin
          phase_d = 1'b1;
          pos_d   = PW'(hi_q) + PW'(1);
        end
      end
      ST_UPD_WR: pos_d = pos_q + low_bit;
      ST_SUM_RD: begin
        if (rv_q) begin
          s_acc_d = s_acc_q + slope_rdata;
          o_acc_d = o_acc_q + offset_rdata;
        end
        if (pos_q != '0) begin
          rv_d  = 1'b1;
          pos_d = pos_q & (pos_q - PW'(1));
        end
      end
      ST_MUL_LO: mlo_d = WORD_W'(mprod);
      ST_MUL_HI: begin
        mhi_d  = mprod_hi;
        term_d = mlo_q + o_acc_q;
      end
      ST_MUL_ADD: term_d = term_q + {mhi_q, 32'b0};
      ST_ACC: begin
        total_d = phase_q ? (total_q - term_q) : (total_q + term_q);
        if (phase_q) begin
          valid_d  = 1'b1;
          result_d = total_d;
        end else begin
          phase_d = 1'b1;
          pos_d   = PW'(lo_m1);
          s_acc_d = '0;
          o_acc_d = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rv_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    phase_q  <= phase_d;
    off_a_q  <= off_a_d;
    off_b_q  <= off_b_d;
    s_acc_q  <= s_acc_d;
    o_acc_q  <= o_acc_d;
    mlo_q    <= mlo_d;
    mhi_q    <= mhi_d;
    term_q   <= term_d;
    total_q  <= total_d;
    result_q <= result_d;
  end

  assign valid_o       = valid_q;
  assign range_total_o = $signed(result_q);

  // slope tree
  fra_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slope_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (slope_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (slope_rdata)
  );

  // offset tree
  fra_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (offset_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (offset_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/fra_chk.sv @@
// port-level checks of the range-add / range-sum store, bound to the top level
`default_nettype none

module fra_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o
);

  // the clearing pass holds off commands straight after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("busy low straight after reset");

  // every accepted command is followed by busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command transfer not followed by busy");

  // a result is shown as the block goes idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a busy stretch");

  // results are single-cycle strobes
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind fenwick_range_add_range_sum fra_chk u_fra_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);

`default_nettype wire

@@ test/testbench.sv @@
// testbench for the fenwick range-add / range-sum store, self-checking against a shadow tree pair
`timescale 1ns / 100ps

module testbench;
  import fra_pkg::*;

  localparam int unsigned STORE_SIZE = 1024;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               mode_i = 1'b0;
  logic [10:0]        lo_index_i = '0;
  logic [10:0]        hi_index_i = '0;
  logic signed [31:0] add_value_i = '0;
  logic               valid_o;
  logic signed [63:0] range_total_o;

  // shadow copies of both trees, entry 0 unused
  logic [63:0] slope_shadow  [0:STORE_SIZE];
  logic [63:0] offset_shadow [0:STORE_SIZE];

  logic [63:0] pending_totals [$];
  logic [63:0] wanted_total;
  int unsigned error_count = 0;
  int          burst_left  = 0;

  fenwick_range_add_range_sum #(
    .SIZE(STORE_SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .lo_index_i   (lo_index_i),
    .hi_index_i   (hi_index_i),
    .add_value_i  (add_value_i),
    .valid_o      (valid_o),
    .range_total_o(range_total_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // upward walk: add delta at pos and every covering node, skipping past the end
  function automatic void bump_point(input bit on_offset, input int unsigned pos,
                                     input logic [63:0] delta);
    int unsigned p;
    p = pos;
    while (p >= 1 && p <= STORE_SIZE) begin
      if (on_offset) offset_shadow[p] += delta;
      else slope_shadow[p] += delta;
      p += p & (~p + 1);
    end
  endfunction

  // downward walk: prefix of one tree up to pos
  function automatic logic [63:0] tree_prefix_sum(input bit on_offset, input int unsigned pos);
    int unsigned p;
    logic [63:0] acc;
    p = (pos > STORE_SIZE) ? STORE_SIZE : pos;
    acc = '0;
    while (p != 0) begin
      acc += on_offset ? offset_shadow[p] : slope_shadow[p];
      p &= p - 1;
    end
    return acc;
  endfunction

  // add v to every element of 1..h
  function automatic void add_upto(input int unsigned h, input logic [63:0] v);
    bump_point(1'b0, 1, v);
    bump_point(1'b0, h + 1, 64'd0 - v);
    bump_point(1'b1, h + 1, 64'(h) * v);
  endfunction

  // total of elements 1..x
  function automatic logic [63:0] total_through(input int unsigned x);
    return tree_prefix_sum(1'b0, x) * 64'(x) + tree_prefix_sum(1'b1, x);
  endfunction

  // apply one accepted command to the shadow trees, queue the total it yields
  function automatic void account_item(input mode_e m, input logic [10:0] lo_raw,
                                       input logic [10:0] hi_raw, input logic [31:0] val);
    int unsigned lo;
    int unsigned hi;
    logic [63:0] wide_val;
    lo = lo_raw;
    hi = hi_raw;
    wide_val = {{32{val[31]}}, val};
    if (lo == 0) lo = 1;
    if (lo > STORE_SIZE + 1) lo = STORE_SIZE + 1;
    if (hi > STORE_SIZE) hi = STORE_SIZE;
    if (m == MODE_ADD) begin
      add_upto(lo - 1, 64'd0 - wide_val);
      add_upto(hi, wide_val);
    end else begin
      pending_totals.push_back(total_through(hi) - total_through(lo - 1));
    end
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // one command transfer, then keep start up within a burst or drop it for a gap
  task automatic send_item(input mode_e m, input logic [10:0] lo, input logic [10:0] hi,
                           input logic [31:0] val);
    int gap;
    start       <= 1'b1;
    mode_i      <= m;
    lo_index_i  <= lo;
    hi_index_i  <= hi;
    add_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    account_item(m, lo, hi, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // random signed amount: small, full width or at the extremes, a third each
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($signed($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  // field extremes and every edge case of index handling
  task automatic test_boundaries();
    send_item(MODE_ADD, 11'd1,    11'd1024, 32'h7FFF_FFFF);
    send_item(MODE_SUM, 11'd1,    11'd1024, 32'h0);
    send_item(MODE_ADD, 11'd1,    11'd1,    32'h8000_0000);
    send_item(MODE_ADD, 11'd1024, 11'd1024, 32'hFFFF_FFFF);
    send_item(MODE_SUM, 11'd1,    11'd1,    32'h0);
    send_item(MODE_SUM, 11'd1024, 11'd1024, 32'h0);
    // zero lo index
    send_item(MODE_ADD, 11'd0,    11'd10,   32'd5);
    send_item(MODE_SUM, 11'd0,    11'd10,   32'h0);
    // hi past the end of the store
    send_item(MODE_ADD, 11'd300,  11'd2047, 32'd7);
    send_item(MODE_SUM, 11'd1000, 11'd2047, 32'h0);
    // range wholly past the end
    send_item(MODE_ADD, 11'd2047, 11'd2047, 32'd9);
    send_item(MODE_SUM, 11'd1025, 11'd2047, 32'h0);
    // reversed ranges
    send_item(MODE_ADD, 11'd500,  11'd100,  32'd3);
    send_item(MODE_SUM, 11'd500,  11'd100,  32'h0);
    send_item(MODE_SUM, 11'd1025, 11'd1024, 32'h0);
    send_item(MODE_ADD, 11'd0,    11'd0,    32'h7FFF_FFFF);
    send_item(MODE_SUM, 11'd2047, 11'd0,    32'h0);
    // amount ignored on a sum, zero add
    send_item(MODE_SUM, 11'd1,    11'd1024, 32'hDEAD_BEEF);
    send_item(MODE_ADD, 11'd513,  11'd768,  32'h0);
    send_item(MODE_SUM, 11'd512,  11'd513,  32'h0);
    send_item(MODE_SUM, 11'd1,    11'd1024, 32'h0);
  endtask

  // well-formed ranges inside the store, wide and narrow
  task automatic test_random_traffic(input int count);
    logic [10:0] lo;
    logic [10:0] hi;
    mode_e       m;
    repeat (count) begin
      lo = 11'($urandom_range(1, STORE_SIZE));
      if ($urandom_range(0, 2) == 0) hi = 11'($urandom_range(lo, STORE_SIZE));
      else hi = 11'($urandom_range(lo, (lo + 16 > STORE_SIZE) ? STORE_SIZE : lo + 16));
      m = mode_e'($urandom_range(0, 1));
      send_item(m, lo, hi, pick_value());
    end
  endtask

  // arbitrary 11-bit indices: zero, reversed and past-the-end ranges
  task automatic test_out_of_range(input int count);
    mode_e m;
    repeat (count) begin
      m = mode_e'($urandom_range(0, 1));
      send_item(m, 11'($urandom), 11'($urandom), pick_value());
    end
  endtask

  // compare every result strobe with the oldest queued total
  always @(posedge clk_i) begin
    if (rst_ni && valid_o !== 1'b0) begin
      if (pending_totals.size() == 0) begin
        report_error($sformatf("unexpected result %h", range_total_o));
      end else begin
        wanted_total = pending_totals.pop_front();
        if (range_total_o !== wanted_total)
          report_error($sformatf("range_total %h, wanted %h", range_total_o, wanted_total));
      end
    end
  end

  // sequence of tests
  initial begin
    for (int i = 0; i <= STORE_SIZE; i++) begin
      slope_shadow[i]  = '0;
      offset_shadow[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundaries();
    test_random_traffic(1000);
    test_out_of_range(250);
    start <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
